[rtl/rsrm_pkg.sv]
// ----------------------------------------------------------------------------
// rsrm_pkg
// Shared constants and types for the running statistics and rate monitor:
// default widths, item kind codes, register map, sequencer states and the
// status bundle of the shared divider.
// ----------------------------------------------------------------------------
package rsrm_pkg;

  // default widths of sample values and totals
  localparam int VALUE_WIDTH_DEF = 24;
  localparam int TOTAL_WIDTH_DEF = 40;

  // fixed widths of timer, tick delta and counters
  localparam int TIMER_W = 32;
  localparam int DELTA_W = 16;
  localparam int COUNT_W = 32;

  // rate scaling: total * 1000 fits in ten extra bits
  localparam int RATE_EXT_W = 10;
  localparam logic [TIMER_W-1:0] RATE_MIN_MS = 32'd1000;

  // item kind codes
  localparam int KIND_W = 2;
  localparam logic [KIND_W-1:0] KIND_EVENT   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TICK    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RESTART = 2'd2;

  // register map: word addressed, bit 2 picks the register
  localparam int ADDR_W      = 3;
  localparam int DATA_W      = 32;
  localparam int REG_SEL_BIT = 2;
  localparam logic REG_MAX_DURATION  = 1'b0;
  localparam logic REG_RESTART_DELAY = 1'b1;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LOAD = 4'b0010,
    ST_WAIT = 4'b0100,
    ST_PUSH = 4'b1000
  } state_t;

  // divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

[rtl/rsrm_div.sv]
// ----------------------------------------------------------------------------
// rsrm_div
// Iterative unsigned restoring divider, two quotient bits per cycle.
// Divides a NUM_W-bit numerator by a 32-bit divisor; done pulses for one
// cycle once the quotient is ready.
// ----------------------------------------------------------------------------
module rsrm_div #(
  parameter int NUM_W = rsrm_pkg::TOTAL_WIDTH_DEF + rsrm_pkg::RATE_EXT_W
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [NUM_W-1:0]            numer,
  input  logic [rsrm_pkg::TIMER_W-1:0] denom,
  output logic [NUM_W-1:0]            quot,
  output rsrm_pkg::div_stat_t         stat
);
  import rsrm_pkg::*;

  localparam int STEPS = (NUM_W + 1) / 2;
  localparam int PAD_W = 2 * STEPS;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic [PAD_W-1:0]   quo_r, quo_nxt;
  logic [TIMER_W-1:0] rem_r, rem_nxt;
  logic [TIMER_W-1:0] den_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               busy_r, done_r;

  logic [PAD_W-1:0]   q_v;
  logic [TIMER_W-1:0] rem_v;
  logic [TIMER_W:0]   trial;

  // two restoring steps per cycle
  always_comb begin
    q_v   = quo_r;
    rem_v = rem_r;
    trial = '0;
    for (int i = 0; i < 2; i++) begin
      trial = {rem_v, q_v[PAD_W-1]};
      q_v   = {q_v[PAD_W-2:0], 1'b0};
      if (trial >= {1'b0, den_r}) begin
        trial  = trial - {1'b0, den_r};
        q_v[0] = 1'b1;
      end
      rem_v = trial[TIMER_W-1:0];
    end
    quo_nxt = q_v;
    rem_nxt = rem_v;
  end

  // busy, done and iteration count registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(STEPS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= PAD_W'(numer);
      rem_r <= '0;
      den_r <= denom;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quot      = quo_r[NUM_W-1:0];
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

[rtl/running_stats_rate_monitor.sv]
// ----------------------------------------------------------------------------
// running_stats_rate_monitor
// Min, max, saturating total and per-second rate for a reduced and a raw
// value channel, with event counters, a measurement timer and auto restart.
// ----------------------------------------------------------------------------
// One transaction is taken at a time and gives one result. An item that
// refreshes the rates (an event inside the window, or the tick that ends the
// window) holds off the next one until both rates are formed: both rates
// come from one radix-4 serial divider (total*1000 / elapsed_ms), channel
// after channel. While elapsed_ms is at most 1000 the rate equals the total
// and the divider is not started; ticks without rate refresh, restarts and
// unused kinds go straight to the result. The result sits in an output
// register; a stalled result holds the next transaction in ST_PUSH until it
// is taken. Configuration writes take effect at once and do not restart the
// measurement.
module running_stats_rate_monitor #(
  parameter int VALUE_WIDTH = rsrm_pkg::VALUE_WIDTH_DEF,
  parameter int TOTAL_WIDTH = rsrm_pkg::TOTAL_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rsrm_pkg::ADDR_W-1:0]   paddr,
  input  logic [rsrm_pkg::DATA_W-1:0]   pwdata,
  output logic [rsrm_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [rsrm_pkg::KIND_W-1:0]   in_kind,
  input  logic [VALUE_WIDTH-1:0]        in_reduced_value,
  input  logic [VALUE_WIDTH-1:0]        in_raw_value,
  input  logic                          in_is_special,
  input  logic [rsrm_pkg::DELTA_W-1:0]  in_delta_ms,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [TOTAL_WIDTH-1:0]        out_reduced_total,
  output logic [TOTAL_WIDTH-1:0]        out_reduced_rate,
  output logic [VALUE_WIDTH-1:0]        out_reduced_min,
  output logic [VALUE_WIDTH-1:0]        out_reduced_max,
  output logic [TOTAL_WIDTH-1:0]        out_raw_total,
  output logic [TOTAL_WIDTH-1:0]        out_raw_rate,
  output logic [VALUE_WIDTH-1:0]        out_raw_min,
  output logic [VALUE_WIDTH-1:0]        out_raw_max,
  output logic [rsrm_pkg::COUNT_W-1:0]  out_event_count,
  output logic [rsrm_pkg::COUNT_W-1:0]  out_special_count,
  output logic [rsrm_pkg::TIMER_W-1:0]  out_elapsed_ms,
  output logic                          out_running
);
  import rsrm_pkg::*;

  localparam int NUM_W = TOTAL_WIDTH + RATE_EXT_W;
  localparam int SUM_W = ((TOTAL_WIDTH > VALUE_WIDTH) ? TOTAL_WIDTH : VALUE_WIDTH) + 1;
  localparam logic [TOTAL_WIDTH-1:0] TOT_MAX = '1;

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] min_v;
    logic [VALUE_WIDTH-1:0] max_v;
    logic [TOTAL_WIDTH-1:0] total;
  } chan_t;

  // fold one sample into a channel
  function automatic chan_t chan_add(chan_t c, logic [VALUE_WIDTH-1:0] v);
    chan_t            r;
    logic [SUM_W-1:0] s;
    r = c;
    s = SUM_W'(c.total) + SUM_W'(v);
    if (c.min_v == '0 || v < c.min_v) r.min_v = v;
    if (v > c.max_v) r.max_v = v;
    r.total = (s > SUM_W'(TOT_MAX)) ? TOT_MAX : s[TOTAL_WIDTH-1:0];
    return r;
  endfunction

  // saturating counter step
  function automatic logic [COUNT_W-1:0] sat_inc(logic [COUNT_W-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  // saturating timer add
  function automatic logic [TIMER_W-1:0] sat_add_ms(logic [TIMER_W-1:0] t,
                                                   logic [DELTA_W-1:0] d);
    logic [TIMER_W:0] s;
    s = {1'b0, t} + (TIMER_W + 1)'(d);
    return s[TIMER_W] ? '1 : s[TIMER_W-1:0];
  endfunction

  // configuration registers
  logic [TIMER_W-1:0] max_dur_r, restart_dly_r;
  logic               cfg_wr;

  // statistics state
  chan_t              red_r, red_nxt, raw_r, raw_nxt;
  logic [TOTAL_WIDTH-1:0] red_rate_r, red_rate_nxt, raw_rate_r, raw_rate_nxt;
  logic [COUNT_W-1:0] evt_cnt_r, evt_cnt_nxt, spc_cnt_r, spc_cnt_nxt;
  logic [TIMER_W-1:0] timer_r, timer_nxt, idle_r, idle_nxt;
  logic               running_r, running_nxt, seen_r, seen_nxt;

  // sequencer
  state_t             state_r, state_nxt;
  logic               ch_r, ch_nxt;
  logic               in_acc, need_rate, restart, out_load;
  logic               out_valid_r;
  logic [TIMER_W-1:0] idle_sum;

  // divider interface
  logic                   div_start;
  logic [TOTAL_WIDTH-1:0] sel_total, rate_div;
  logic [NUM_W-1:0]       numer, quot;
  div_stat_t              div_stat;

  // apb register file
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign prdata = (paddr[REG_SEL_BIT] == REG_RESTART_DELAY) ? restart_dly_r : max_dur_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_dur_r     <= '0;
      restart_dly_r <= '0;
    end else if (cfg_wr) begin
      if (paddr[REG_SEL_BIT] == REG_MAX_DURATION) max_dur_r <= pwdata;
      else restart_dly_r <= pwdata;
    end
  end

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;

  // numerator total*1000 and saturated quotient
  assign sel_total = ch_r ? raw_r.total : red_r.total;
  assign numer = (NUM_W'(sel_total) << 10) - (NUM_W'(sel_total) << 4)
               - (NUM_W'(sel_total) << 3);
  assign rate_div = (|quot[NUM_W-1:TOTAL_WIDTH]) ? TOT_MAX : quot[TOTAL_WIDTH-1:0];
  assign idle_sum = sat_add_ms(idle_r, in_delta_ms);

  // item update and rate write-back
  always_comb begin
    red_nxt      = red_r;
    raw_nxt      = raw_r;
    red_rate_nxt = red_rate_r;
    raw_rate_nxt = raw_rate_r;
    evt_cnt_nxt  = evt_cnt_r;
    spc_cnt_nxt  = spc_cnt_r;
    timer_nxt    = timer_r;
    idle_nxt     = idle_r;
    running_nxt  = running_r;
    seen_nxt     = seen_r;
    need_rate    = 1'b0;
    restart      = 1'b0;
    state_nxt    = state_r;
    ch_nxt       = ch_r;
    div_start    = 1'b0;
    out_load     = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          priority if (in_kind == KIND_EVENT) begin
            if (!(max_dur_r != '0 && timer_r >= max_dur_r)) begin
              running_nxt = 1'b1;
              evt_cnt_nxt = sat_inc(evt_cnt_r);
              if (in_is_special) spc_cnt_nxt = sat_inc(spc_cnt_r);
              red_nxt = chan_add(red_r, in_reduced_value);
              raw_nxt = chan_add(raw_r, in_raw_value);
              if (in_raw_value != '0) seen_nxt = 1'b1;
              need_rate = 1'b1;
            end
          end else if (in_kind == KIND_TICK) begin
            // timer runs up to the window end, then stops and clamps
            if (running_r) begin
              if (max_dur_r == '0 || timer_r < max_dur_r) begin
                timer_nxt = sat_add_ms(timer_r, in_delta_ms);
              end else begin
                running_nxt = 1'b0;
                timer_nxt   = max_dur_r;
                need_rate   = 1'b1;
              end
            end
            // idle watch for auto restart
            if (restart_dly_r != '0) begin
              if (!seen_r) begin
                idle_nxt = idle_sum;
                if (idle_sum > restart_dly_r) restart = 1'b1;
              end else begin
                idle_nxt = '0;
              end
            end
            seen_nxt = 1'b0;
          end else if (in_kind == KIND_RESTART) begin
            restart = 1'b1;
          end else begin
            restart = 1'b0;
          end
          if (restart) begin
            red_nxt      = '0;
            raw_nxt      = '0;
            red_rate_nxt = '0;
            raw_rate_nxt = '0;
            evt_cnt_nxt  = '0;
            spc_cnt_nxt  = '0;
            timer_nxt    = '0;
            idle_nxt     = '0;
            running_nxt  = 1'b0;
            seen_nxt     = 1'b0;
            need_rate    = 1'b0;
          end
          ch_nxt    = 1'b0;
          state_nxt = need_rate ? ST_LOAD : ST_PUSH;
        end
      end
      ST_LOAD: begin
        // short windows report the plain total
        if (timer_r > RATE_MIN_MS) begin
          div_start = 1'b1;
          state_nxt = ST_WAIT;
        end else begin
          if (ch_r) raw_rate_nxt = raw_r.total;
          else red_rate_nxt = red_r.total;
          ch_nxt    = 1'b1;
          state_nxt = ch_r ? ST_PUSH : ST_LOAD;
        end
      end
      ST_WAIT: begin
        if (div_stat.done) begin
          if (ch_r) raw_rate_nxt = rate_div;
          else red_rate_nxt = rate_div;
          ch_nxt    = 1'b1;
          state_nxt = ch_r ? ST_PUSH : ST_LOAD;
        end
      end
      ST_PUSH: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ch_r        <= 1'b0;
      red_r       <= '0;
      raw_r       <= '0;
      red_rate_r  <= '0;
      raw_rate_r  <= '0;
      evt_cnt_r   <= '0;
      spc_cnt_r   <= '0;
      timer_r     <= '0;
      idle_r      <= '0;
      running_r   <= 1'b0;
      seen_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ch_r        <= ch_nxt;
      red_r       <= red_nxt;
      raw_r       <= raw_nxt;
      red_rate_r  <= red_rate_nxt;
      raw_rate_r  <= raw_rate_nxt;
      evt_cnt_r   <= evt_cnt_nxt;
      spc_cnt_r   <= spc_cnt_nxt;
      timer_r     <= timer_nxt;
      idle_r      <= idle_nxt;
      running_r   <= running_nxt;
      seen_r      <= seen_nxt;
      out_valid_r <= out_load || (out_valid_r && out_stall);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_reduced_total <= red_r.total;
      out_reduced_rate  <= red_rate_r;
      out_reduced_min   <= red_r.min_v;
      out_reduced_max   <= red_r.max_v;
      out_raw_total     <= raw_r.total;
      out_raw_rate      <= raw_rate_r;
      out_raw_min       <= raw_r.min_v;
      out_raw_max       <= raw_r.max_v;
      out_event_count   <= evt_cnt_r;
      out_special_count <= spc_cnt_r;
      out_elapsed_ms    <= timer_r;
      out_running       <= running_r;
    end
  end

  assign out_valid = out_valid_r;

  // shared divider
  rsrm_div #(
    .NUM_W (NUM_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .numer (numer),
    .denom (timer_r),
    .quot  (quot),
    .stat  (div_stat)
  );

  // divider is only started when idle
  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  // an accepted transaction closes the input until its result is formed
  a_stall_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> in_stall)
    else $error("input open right after acceptance");

  // a waiting result is never overwritten
  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PUSH && out_valid_r && out_stall) |=> state_r == ST_PUSH)
    else $error("result register overwritten");

  // min is either unset or not above max
  a_min_max: assert property (@(posedge clk) disable iff (!rst_n)
    (red_r.min_v <= red_r.max_v) && (raw_r.min_v <= raw_r.max_v))
    else $error("channel min above max");

endmodule
